@@ rtl/lci_pkg.sv @@
// Package with the calibration tables, request codes and sizes of the lens calibration interpolator.
`timescale 1ns / 1ps
package lci_pkg;

	localparam int ZOOM_POINTS  = 17;
	localparam int FOCUS_POINTS = 9;
	localparam int FRAC_BITS    = 16;
	localparam int TOTAL_POINTS = 2 * ZOOM_POINTS + FOCUS_POINTS;
	localparam int ROM_ZOOM     = 17;
	localparam int ROM_FOCUS    = 9;
	localparam int IDX_W        = $clog2(TOTAL_POINTS + 1);
	localparam int DIV_STEPS    = 32;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

	localparam logic [IDX_W-1:0] FOCAL_BASE = IDX_W'(0);
	localparam logic [IDX_W-1:0] FOV_BASE   = IDX_W'(ZOOM_POINTS);
	localparam logic [IDX_W-1:0] DIST_BASE  = IDX_W'(2 * ZOOM_POINTS);
	localparam logic [IDX_W-1:0] FOCAL_LAST = IDX_W'(ZOOM_POINTS - 1);
	localparam logic [IDX_W-1:0] FOV_LAST   = IDX_W'(2 * ZOOM_POINTS - 1);
	localparam logic [IDX_W-1:0] DIST_LAST  = IDX_W'(TOTAL_POINTS - 1);

	localparam logic [1:0] REQ_FOCAL    = 2'd0;
	localparam logic [1:0] REQ_FOV      = 2'd1;
	localparam logic [1:0] REQ_DISTANCE = 2'd2;
	localparam logic [1:0] REQ_INVERSE  = 2'd3;

	typedef logic [15:0] pulse_tbl_t [TOTAL_POINTS];
	typedef logic [31:0] value_tbl_t [TOTAL_POINTS];

	localparam logic [15:0] ROM_ZOOM_PULSE [ROM_ZOOM] = '{
		16'd0, 16'd4096, 16'd8192, 16'd12288, 16'd16384, 16'd20480, 16'd24576,
		16'd28672, 16'd32768, 16'd36864, 16'd40960, 16'd45056, 16'd49152,
		16'd53248, 16'd57344, 16'd61440, 16'd65535
	};
	localparam logic [31:0] ROM_FOCAL_MILLI [ROM_ZOOM] = '{
		32'd20000, 32'd23500, 32'd28200, 32'd35100, 32'd45300, 32'd58700,
		32'd76500, 32'd100800, 32'd134400, 32'd180200, 32'd243600, 32'd330100,
		32'd442800, 32'd580400, 32'd680000, 32'd750000, 32'd800000
	};
	localparam logic [31:0] ROM_FOV_MILLI [ROM_ZOOM] = '{
		32'd20974, 32'd17850, 32'd14880, 32'd11960, 32'd9270, 32'd7160,
		32'd5490, 32'd4170, 32'd3130, 32'd2330, 32'd1720, 32'd1270,
		32'd950, 32'd725, 32'd619, 32'd561, 32'd541
	};
	localparam logic [15:0] ROM_FOCUS_PULSE [ROM_FOCUS] = '{
		16'd0, 16'd8192, 16'd16384, 16'd24576, 16'd32768, 16'd40960,
		16'd49152, 16'd57344, 16'd65535
	};
	localparam logic [31:0] ROM_DIST_MILLI [ROM_FOCUS] = '{
		32'd5000, 32'd7500, 32'd12000, 32'd25000, 32'd50000, 32'd120000,
		32'd350000, 32'd1200000, 32'd5000000
	};

	// Thousandths to fixed point, rounded half up and saturated.
	function automatic logic [31:0] milli_to_fixed(logic [31:0] milli);
		logic [63:0] v;
		v = ((64'(milli) << FRAC_BITS) + 64'd500) / 64'd1000;
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic pulse_tbl_t build_pulses();
		pulse_tbl_t t;
		int k;
		for (int i = 0; i < TOTAL_POINTS; i++) begin
			if (i < ZOOM_POINTS) begin
				k = (i < ROM_ZOOM) ? i : ROM_ZOOM - 1;
				t[i] = ROM_ZOOM_PULSE[k];
			end else if (i < 2 * ZOOM_POINTS) begin
				k = (i - ZOOM_POINTS < ROM_ZOOM) ? i - ZOOM_POINTS : ROM_ZOOM - 1;
				t[i] = ROM_ZOOM_PULSE[k];
			end else begin
				k = (i - 2 * ZOOM_POINTS < ROM_FOCUS) ? i - 2 * ZOOM_POINTS : ROM_FOCUS - 1;
				t[i] = ROM_FOCUS_PULSE[k];
			end
		end
		return t;
	endfunction

	function automatic value_tbl_t build_values();
		value_tbl_t t;
		int k;
		for (int i = 0; i < TOTAL_POINTS; i++) begin
			if (i < ZOOM_POINTS) begin
				k = (i < ROM_ZOOM) ? i : ROM_ZOOM - 1;
				t[i] = milli_to_fixed(ROM_FOCAL_MILLI[k]);
			end else if (i < 2 * ZOOM_POINTS) begin
				k = (i - ZOOM_POINTS < ROM_ZOOM) ? i - ZOOM_POINTS : ROM_ZOOM - 1;
				t[i] = milli_to_fixed(ROM_FOV_MILLI[k]);
			end else begin
				k = (i - 2 * ZOOM_POINTS < ROM_FOCUS) ? i - 2 * ZOOM_POINTS : ROM_FOCUS - 1;
				t[i] = milli_to_fixed(ROM_DIST_MILLI[k]);
			end
		end
		return t;
	endfunction

	localparam pulse_tbl_t POINT_PULSES = build_pulses();
	localparam value_tbl_t POINT_VALUES = build_values();

	// Search column: pulses for forward requests, values for the inverse one.
	function automatic logic [31:0] key_at(logic inv, logic [IDX_W-1:0] idx);
		return inv ? POINT_VALUES[idx] : 32'(POINT_PULSES[idx]);
	endfunction

	// Answer column at a table end.
	function automatic logic [31:0] answer_at(logic inv, logic [IDX_W-1:0] idx);
		return inv ? 32'(POINT_PULSES[idx]) : POINT_VALUES[idx];
	endfunction

endpackage

@@ rtl/lens_calibration_interpolator.sv @@
// Top level of the lens calibration interpolator: sequencer, segment search and serial divider.
`timescale 1ns / 1ps
// The block converts zoom or focus motor pulses to focal length, field of view or
// distance, and focal length back to a zoom pulse, from calibration tables held in
// constant logic. A request word enters on the s_ channel with the conversion kind
// in s_tuser; the answer word leaves on the m_ channel.
// One request is worked on at a time. After the word is taken, the sequencer checks
// the table ends, walks the segment search one point a cycle, forms the product of
// the offset and the span of the segment in the answer column in the multiplier state
// and then runs a restoring divider one quotient bit a cycle. A key at or beyond a
// table end gives its result straight after the end check, and a flat segment after
// the search and the segment check. Any other request also passes the multiplier, the
// 32 divider steps and a final step. The next word is taken only once the sequencer is
// back in idle, so a new request is not taken before the last one is through.
// s_tready is high whenever the sequencer is idle, so a new request is taken while a
// finished result is still held in the output register. If the receiver stalls, the
// next result waits in the sequencer until the output register is free.
// The asynchronous reset empties the output register and returns the sequencer to
// idle; the tables need no loading.
module lens_calibration_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // pulse [15:0], value_in [47:16]
	input  logic [1:0]  s_tuser,  // req_type [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // value_out [31:0], pulse_out [47:32]
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_ENDS = 9'b000000010,
		ST_SCAN = 9'b000000100,
		ST_SEG  = 9'b000001000,
		ST_PREP = 9'b000010000,
		ST_MUL  = 9'b000100000,
		ST_DIV  = 9'b001000000,
		ST_FIN  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t state_q;

	logic                        inv_q;
	logic [31:0]                 key_q;
	logic [lci_pkg::IDX_W-1:0]   base_q;
	logic [lci_pkg::IDX_W-1:0]   last_q;
	logic [lci_pkg::IDX_W-1:0]   sidx_q;
	logic [lci_pkg::IDX_W-1:0]   seg_q;
	logic [15:0]                 p0_q;
	logic [15:0]                 p1_q;
	logic [31:0]                 v0_q;
	logic [31:0]                 v1_q;
	logic [31:0]                 mul_a_q;
	logic [15:0]                 mul_b_q;
	logic [30:0]                 rnd_q;
	logic [31:0]                 div_q;
	logic                        neg_q;
	logic [31:0]                 rem_q;
	logic [31:0]                 quo_q;
	logic [lci_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [31:0]                 res_q;
	logic                        out_valid_q;
	logic [31:0]                 out_value_q;
	logic [15:0]                 out_pulse_q;

	logic [47:0] num;
	logic [32:0] shifted;
	logic        fits;
	logic [32:0] est;
	logic [lci_pkg::IDX_W-1:0] seg_next;
	logic        out_free;

	assign num      = 48'(mul_a_q) * 48'(mul_b_q) + 48'(rnd_q);
	assign shifted  = {rem_q, quo_q[31]};
	assign fits     = shifted >= {1'b0, div_q};
	assign est      = 33'(p0_q) + 33'(quo_q);
	assign seg_next = seg_q + lci_pkg::IDX_W'(1);
	assign out_free = !out_valid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_pulse_q, out_value_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_ENDS;
					end
				end
				ST_ENDS: begin
					if (key_q <= lci_pkg::key_at(inv_q, base_q) ||
					    key_q >= lci_pkg::key_at(inv_q, last_q)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sidx_q >= last_q) begin
						state_q <= ST_SEG;
					end
				end
				ST_SEG:  state_q <= ST_PREP;
				ST_PREP: begin
					if (inv_q ? (v1_q <= v0_q || key_q < v0_q) : (p1_q <= p0_q)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == lci_pkg::DIV_CNT_W'(lci_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				inv_q  <= (s_tuser == lci_pkg::REQ_INVERSE);
				key_q  <= (s_tuser == lci_pkg::REQ_INVERSE) ? s_tdata[47:16]
				                                            : 32'(s_tdata[15:0]);
				case (s_tuser)
					lci_pkg::REQ_FOV: begin
						base_q <= lci_pkg::FOV_BASE;
						last_q <= lci_pkg::FOV_LAST;
					end
					lci_pkg::REQ_DISTANCE: begin
						base_q <= lci_pkg::DIST_BASE;
						last_q <= lci_pkg::DIST_LAST;
					end
					default: begin
						base_q <= lci_pkg::FOCAL_BASE;
						last_q <= lci_pkg::FOCAL_LAST;
					end
				endcase
			end
			ST_ENDS: begin
				seg_q  <= base_q;
				sidx_q <= base_q + lci_pkg::IDX_W'(1);
				if (key_q <= lci_pkg::key_at(inv_q, base_q)) begin
					res_q <= lci_pkg::answer_at(inv_q, base_q);
				end else begin
					res_q <= lci_pkg::answer_at(inv_q, last_q);
				end
			end
			ST_SCAN: begin
				if (sidx_q < last_q) begin
					if (lci_pkg::key_at(inv_q, sidx_q) <= key_q) begin
						seg_q <= sidx_q;
					end
					sidx_q <= sidx_q + lci_pkg::IDX_W'(1);
				end
			end
			ST_SEG: begin
				p0_q <= lci_pkg::POINT_PULSES[seg_q];
				p1_q <= lci_pkg::POINT_PULSES[seg_next];
				v0_q <= lci_pkg::POINT_VALUES[seg_q];
				v1_q <= lci_pkg::POINT_VALUES[seg_next];
			end
			ST_PREP: begin
				if (inv_q) begin
					res_q   <= 32'(p0_q);
					mul_a_q <= key_q - v0_q;
					neg_q   <= p1_q < p0_q;
					mul_b_q <= (p1_q < p0_q) ? (p0_q - p1_q) : (p1_q - p0_q);
					div_q   <= v1_q - v0_q;
					rnd_q   <= 31'((v1_q - v0_q) >> 1);
				end else begin
					res_q   <= v0_q;
					mul_a_q <= (v1_q < v0_q) ? (v0_q - v1_q) : (v1_q - v0_q);
					neg_q   <= v1_q < v0_q;
					mul_b_q <= key_q[15:0] - p0_q;
					div_q   <= 32'(p1_q - p0_q);
					rnd_q   <= 31'((p1_q - p0_q) >> 1);
				end
			end
			ST_MUL: begin
				rem_q <= 32'(num[47:32]);
				quo_q <= num[31:0];
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= fits ? 32'(shifted - {1'b0, div_q}) : shifted[31:0];
				quo_q <= {quo_q[30:0], fits};
				cnt_q <= cnt_q + lci_pkg::DIV_CNT_W'(1);
			end
			ST_FIN: begin
				if (!inv_q) begin
					res_q <= neg_q ? (v0_q - quo_q) : (v0_q + quo_q);
				end else if (neg_q) begin
					res_q <= (quo_q >= 32'(p0_q)) ? 32'd0 : 32'(p0_q - quo_q[15:0]);
				end else begin
					res_q <= (est > 33'd65535) ? 32'd65535 : est[31:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_value_q <= inv_q ? 32'd0 : res_q;
					out_pulse_q <= inv_q ? res_q[15:0] : 16'd0;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ sim/tb_lens_calibration_interpolator.sv @@
// Self-checking testbench of the lens calibration interpolator: directed table, then random words.
`timescale 1ns / 1ps
module tb_lens_calibration_interpolator;

	typedef struct packed {
		logic [15:0] zoom_pulse;
		logic [31:0] optic_value;
	} lens_answer_t;

	typedef struct packed {
		logic [1:0]   kind;
		logic [15:0]  pos;
		logic [31:0]  focal;
		logic         typed_in;
		lens_answer_t answer;
	} stim_row_t;

	localparam int HOLDOFF_CYCLES  = 300;
	localparam int ITEMS_PER_PHASE = 626;
	localparam int DRAIN_CYCLES    = 80;
	localparam int DIRECTED_ROWS   = 24;

	localparam logic [15:0] ZOOM_MARKS [17] = '{
		16'd0, 16'd4096, 16'd8192, 16'd12288, 16'd16384, 16'd20480, 16'd24576,
		16'd28672, 16'd32768, 16'd36864, 16'd40960, 16'd45056, 16'd49152,
		16'd53248, 16'd57344, 16'd61440, 16'd65535
	};
	localparam logic [31:0] FOCAL_THOU [17] = '{
		32'd20000, 32'd23500, 32'd28200, 32'd35100, 32'd45300, 32'd58700,
		32'd76500, 32'd100800, 32'd134400, 32'd180200, 32'd243600, 32'd330100,
		32'd442800, 32'd580400, 32'd680000, 32'd750000, 32'd800000
	};
	localparam logic [31:0] FOV_THOU [17] = '{
		32'd20974, 32'd17850, 32'd14880, 32'd11960, 32'd9270, 32'd7160,
		32'd5490, 32'd4170, 32'd3130, 32'd2330, 32'd1720, 32'd1270,
		32'd950, 32'd725, 32'd619, 32'd561, 32'd541
	};
	localparam logic [15:0] FOCUS_MARKS [9] = '{
		16'd0, 16'd8192, 16'd16384, 16'd24576, 16'd32768, 16'd40960,
		16'd49152, 16'd57344, 16'd65535
	};
	localparam logic [31:0] DIST_THOU [9] = '{
		32'd5000, 32'd7500, 32'd12000, 32'd25000, 32'd50000, 32'd120000,
		32'd350000, 32'd1200000, 32'd5000000
	};

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{lci_pkg::REQ_FOCAL,    16'd0,     32'hFFFF_FFFF, 1'b1, '{16'd0, 32'd1310720}},
		'{lci_pkg::REQ_FOCAL,    16'd65535, 32'd0,         1'b1, '{16'd0, 32'd52428800}},
		'{lci_pkg::REQ_FOCAL,    16'd4096,  32'd0,         1'b1, '{16'd0, 32'd1540096}},
		'{lci_pkg::REQ_FOCAL,    16'd1,     32'd0,         1'b0, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_FOCAL,    16'd65534, 32'd0,         1'b0, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_FOCAL,    16'd30000, 32'd0,         1'b0, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_FOV,      16'd0,     32'd0,         1'b1, '{16'd0, 32'd1374552}},
		'{lci_pkg::REQ_FOV,      16'd65535, 32'd0,         1'b1, '{16'd0, 32'd35455}},
		'{lci_pkg::REQ_FOV,      16'd2048,  32'd0,         1'b0, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_FOV,      16'd61441, 32'd0,         1'b0, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_DISTANCE, 16'd0,     32'd0,         1'b1, '{16'd0, 32'd327680}},
		'{lci_pkg::REQ_DISTANCE, 16'd65535, 32'd0,         1'b1, '{16'd0, 32'd327680000}},
		'{lci_pkg::REQ_DISTANCE, 16'd8192,  32'd0,         1'b1, '{16'd0, 32'd491520}},
		'{lci_pkg::REQ_DISTANCE, 16'd65534, 32'd0,         1'b0, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_DISTANCE, 16'd4096,  32'd0,         1'b0, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_INVERSE,  16'hFFFF,  32'd0,         1'b1, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_INVERSE,  16'd0,     32'hFFFF_FFFF, 1'b1, '{16'd65535, 32'd0}},
		'{lci_pkg::REQ_INVERSE,  16'd0,     32'd1310720,   1'b1, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_INVERSE,  16'd0,     32'd52428800,  1'b1, '{16'd65535, 32'd0}},
		'{lci_pkg::REQ_INVERSE,  16'd0,     32'd1540096,   1'b1, '{16'd4096, 32'd0}},
		'{lci_pkg::REQ_INVERSE,  16'd0,     32'd1310721,   1'b0, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_INVERSE,  16'd0,     32'd52428799,  1'b0, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_INVERSE,  16'd0,     32'd20000000,  1'b0, '{16'd0, 32'd0}},
		'{lci_pkg::REQ_FOCAL,    16'h5555,  32'hFFFF_FFFF, 1'b0, '{16'd0, 32'd0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = lci_pkg::REQ_FOCAL;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	logic [15:0]  cal_pulse [lci_pkg::TOTAL_POINTS];
	logic [31:0]  cal_value [lci_pkg::TOTAL_POINTS];
	lens_answer_t pending_answers [$];
	int           mismatches = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           holdoff_requests = 0;

	lens_calibration_interpolator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [31:0] thou_to_q16(logic [31:0] thou);
		logic [63:0] q;
		q = ((64'(thou) << lci_pkg::FRAC_BITS) + 64'd500) / 64'd1000;
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic logic [31:0] lookup_optic(int base, int n, logic [15:0] key);
		int          seg;
		logic [31:0] p0, w, v0, v1;
		logic [63:0] step;
		if (key <= cal_pulse[base]) return cal_value[base];
		if (key >= cal_pulse[base+n-1]) return cal_value[base+n-1];
		seg = 0;
		for (int j = 1; j + 1 < n; j++)
			if (cal_pulse[base+j] <= key) seg = j;
		p0 = 32'(cal_pulse[base+seg]);
		w  = 32'(cal_pulse[base+seg+1]) - p0;
		v0 = cal_value[base+seg];
		v1 = cal_value[base+seg+1];
		if (32'(cal_pulse[base+seg+1]) <= p0 || w == 0) return v0;
		// The rounded step goes away from the first point whichever way the segment slopes.
		if (v1 >= v0) begin
			step = (64'(v1 - v0) * 64'(32'(key) - p0) + 64'(w >> 1)) / 64'(w);
			return v0 + step[31:0];
		end
		step = (64'(v0 - v1) * 64'(32'(key) - p0) + 64'(w >> 1)) / 64'(w);
		return v0 - step[31:0];
	endfunction

	function automatic logic [15:0] lookup_zoom(int base, int n, logic [31:0] val);
		int          seg;
		logic [31:0] v0, dv, off, p0, p1;
		logic [63:0] est, d;
		if (val <= cal_value[base]) return cal_pulse[base];
		if (val >= cal_value[base+n-1]) return cal_pulse[base+n-1];
		seg = 0;
		for (int j = 1; j + 1 < n; j++)
			if (cal_value[base+j] <= val) seg = j;
		v0 = cal_value[base+seg];
		p0 = 32'(cal_pulse[base+seg]);
		p1 = 32'(cal_pulse[base+seg+1]);
		if (cal_value[base+seg+1] <= v0 || val < v0) return p0[15:0];
		dv  = cal_value[base+seg+1] - v0;
		off = val - v0;
		if (p1 >= p0) begin
			est = 64'(p0) + (64'(off) * 64'(p1 - p0) + 64'(dv >> 1)) / 64'(dv);
		end else begin
			d   = (64'(off) * 64'(p0 - p1) + 64'(dv >> 1)) / 64'(dv);
			est = (d >= 64'(p0)) ? 64'd0 : 64'(p0) - d;
		end
		return (est > 64'd65535) ? 16'hFFFF : est[15:0];
	endfunction

	function automatic lens_answer_t predict_answer(logic [1:0] kind, logic [15:0] pos,
			logic [31:0] focal);
		lens_answer_t a;
		a = '0;
		case (kind)
			lci_pkg::REQ_FOCAL:
				a.optic_value = lookup_optic(0, lci_pkg::ZOOM_POINTS, pos);
			lci_pkg::REQ_FOV:
				a.optic_value = lookup_optic(lci_pkg::ZOOM_POINTS, lci_pkg::ZOOM_POINTS, pos);
			lci_pkg::REQ_DISTANCE:
				a.optic_value = lookup_optic(2 * lci_pkg::ZOOM_POINTS, lci_pkg::FOCUS_POINTS,
					pos);
			default:
				a.zoom_pulse  = lookup_zoom(0, lci_pkg::ZOOM_POINTS, focal);
		endcase
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic offer_request(logic [1:0] kind, logic [15:0] pos, logic [31:0] focal,
			lens_answer_t answer);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {focal, pos};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_answers.push_back(answer);
	endtask

	always @(posedge clk) begin : receive_side
		lens_answer_t got, want;
		int           holdoff_left;
		int           holdoff_served;
		if (m_tvalid === 1'b1 && m_tready) begin
			got = lens_answer_t'(m_tdata);
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected word", 32'(got), 32'd0);
			end else begin
				want = pending_answers.pop_front();
				if (got.optic_value !== want.optic_value)
					report_mismatch("value_out", got.optic_value, want.optic_value);
				if (got.zoom_pulse !== want.zoom_pulse)
					report_mismatch("pulse_out", 32'(got.zoom_pulse), 32'(want.zoom_pulse));
			end
		end
		if (holdoff_served != holdoff_requests) begin
			holdoff_left = HOLDOFF_CYCLES;
			holdoff_served++;
		end
		if (holdoff_left > 0) begin
			m_tready <= 1'b0;
			holdoff_left--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin : stimulus
		int          k;
		logic [1:0]  kind;
		logic [15:0] pos;
		logic [31:0] focal;
		stim_row_t   row;
		for (int i = 0; i < lci_pkg::TOTAL_POINTS; i++) begin
			if (i < 2 * lci_pkg::ZOOM_POINTS) begin
				k = i % lci_pkg::ZOOM_POINTS;
				k = (k < 17) ? k : 16;
				cal_pulse[i] = ZOOM_MARKS[k];
				cal_value[i] = thou_to_q16((i < lci_pkg::ZOOM_POINTS) ? FOCAL_THOU[k]
				                                                      : FOV_THOU[k]);
			end else begin
				k = i - 2 * lci_pkg::ZOOM_POINTS;
				k = (k < 9) ? k : 8;
				cal_pulse[i] = FOCUS_MARKS[k];
				cal_value[i] = thou_to_q16(DIST_THOU[k]);
			end
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 85 : 0;
			recv_idle_pct <= (phase == 0) ? 85 : (phase == 1) ? 13 : 0;
			if (phase == 0) begin
				for (int r = 0; r < DIRECTED_ROWS; r++) begin
					row = DIRECTED[r];
					offer_request(row.kind, row.pos, row.focal, row.typed_in ? row.answer :
						predict_answer(row.kind, row.pos, row.focal));
				end
			end
			// With no idling the long receiver stall backs the block up into its input.
			if (phase == 2) holdoff_requests <= holdoff_requests + 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				kind  = 2'($urandom_range(0, 3));
				focal = $urandom;
				case ($urandom_range(0, 9))
					0:       pos = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					1:       pos = 16'(32'(ZOOM_MARKS[$urandom_range(0, 16)]) +
							$urandom_range(0, 2) - 1);
					default: pos = 16'($urandom);
				endcase
				if (kind == lci_pkg::REQ_INVERSE) begin
					case ($urandom_range(0, 9))
						0, 1, 2: focal = $urandom;
						3:       focal = cal_value[$urandom_range(0, lci_pkg::ZOOM_POINTS - 1)] +
								$urandom_range(0, 2) - 1;
						default: focal = $urandom_range(cal_value[0],
								cal_value[lci_pkg::ZOOM_POINTS - 1]);
					endcase
				end
				offer_request(kind, pos, focal, predict_answer(kind, pos, focal));
			end
			s_tvalid <= 1'b0;
			while (pending_answers.size() != 0) @(posedge clk);
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lci_pkg.sv
rtl/lens_calibration_interpolator.sv
sim/tb_lens_calibration_interpolator.sv
